[rtl/rlre_pkg.sv]
// Shared types and constants for the row run-length encoder.
`default_nettype none

package rlre_pkg;

    // Fixed field widths of the channels and the configuration port.
    localparam int VALUE_W     = 16;
    localparam int COUNT_W     = 8;
    localparam int TALLY_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int DEF_MAX_ROW_LEN = 255;

    // One element can close a run, close its row and close the array.
    localparam int RESULTS_MAX = 3;
    localparam int QUEUE_DEPTH = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_TOTAL  = 2'd1;

    // Codes of the kind field.
    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // One result item as it leaves the block.
    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] run_value;
        logic [COUNT_W-1:0] run_count;
        logic               row_end;
        logic [TALLY_W-1:0] total_runs;
        logic               compressible;
        logic               last;
    } result_t;

    // Results produced by one element, packed from slot 0 upward.
    typedef struct packed {
        logic [1:0]                    count;
        result_t [RESULTS_MAX-1:0]     slot;
    } push_t;

endpackage

`default_nettype wire

[rtl/row_run_length_encoder_top.sv]
// Top level of the row run-length encoder.
// Elements enter one per cycle in row-major order; each transfer updates the
// run state in the same clock edge and pushes zero to three results (a run
// closed by a value change, the run that closes the row, and the verdict
// after the last row) into an eight-entry result queue. Results leave in order,
// one per cycle while out_ready is high. The input stays ready while at least
// three queue entries are free, so a stream sustains one element per cycle as
// long as it produces on average no more than one result per element and the
// consumer keeps taking them. The user writes row_length and row_total through
// the configuration port only while no element is in flight; the block does not
// enforce this. Zero acts as one.
`default_nettype none

module row_run_length_encoder_top #(
    parameter int VALUE_WIDTH = rlre_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_ROW_LEN = rlre_pkg::DEF_MAX_ROW_LEN
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [rlre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rlre_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [rlre_pkg::VALUE_W-1:0]     value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  kind,
    output logic [rlre_pkg::VALUE_W-1:0]          run_value,
    output logic [rlre_pkg::COUNT_W-1:0]          run_count,
    output logic                                  row_end,
    output logic [rlre_pkg::TALLY_W-1:0]          total_runs,
    output logic                                  compressible,
    output logic                                  last
);
    import rlre_pkg::*;

    push_t   push;
    result_t head;
    logic    in_fire;

    assign in_fire = in_valid && in_ready;

    // Run state and result formation.
    rlre_core #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_ROW_LEN (MAX_ROW_LEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .value        (value),
        .push         (push)
    );

    // Result queue between the encoder and the output channel.
    rlre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (in_ready),
        .head_valid (out_valid),
        .head_taken (out_ready),
        .head       (head)
    );

    // Output fields straight from the queue head.
    assign kind         = head.kind;
    assign run_value    = head.run_value;
    assign run_count    = head.run_count;
    assign row_end      = head.row_end;
    assign total_runs   = head.total_runs;
    assign compressible = head.compressible;
    assign last         = head.last;

endmodule

`default_nettype wire

[rtl/rlre_core.sv]
// Encoder state, configuration registers and per-element result logic.
`default_nettype none

module rlre_core #(
    parameter int VALUE_WIDTH = rlre_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_ROW_LEN = rlre_pkg::DEF_MAX_ROW_LEN
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [rlre_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rlre_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_fire,
    input  wire logic [rlre_pkg::VALUE_W-1:0]     value,
    output rlre_pkg::push_t                       push
);
    import rlre_pkg::*;

    // Only the low bits of an element are kept and compared.
    localparam int KEEP_W = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_ROW_LEN);
    localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_TOP = '1;
    localparam logic [TALLY_W-1:0] TALLY_TOP = '1;

    logic [COUNT_W-1:0] row_length_reg;
    logic [COUNT_W-1:0] row_total_reg;

    logic [KEEP_W-1:0]  held_value_reg,  held_value_next;
    logic [COUNT_W-1:0] run_length_reg,  run_length_next;
    logic [COUNT_W-1:0] column_pos_reg,  column_pos_next;
    logic [COUNT_W-1:0] row_pos_reg,     row_pos_next;
    logic [TALLY_W-1:0] run_tally_reg,   run_tally_next;

    logic [KEEP_W-1:0]  elem;
    logic [COUNT_W-1:0] len_eff;
    logic [COUNT_W-1:0] rows_eff;
    logic [TALLY_W-1:0] elem_total;
    logic               emit_change;
    logic               emit_row;
    logic               emit_verdict;
    logic [KEEP_W-1:0]  row_value;
    logic [COUNT_W-1:0] row_count;
    logic [TALLY_W-1:0] verdict_tally;
    logic [1:0]         n_results;
    result_t            change_res;
    result_t            row_res;
    result_t            verdict_res;

    // Build a run item from a kept value and its count.
    function automatic result_t make_run(input logic [KEEP_W-1:0] v,
                                         input logic [COUNT_W-1:0] cnt,
                                         input logic rend);
        result_t r;
        r              = '0;
        r.kind         = KIND_RUN;
        r.run_value[KEEP_W-1:0] = v;
        r.run_count    = cnt;
        r.row_end      = rend;
        return r;
    endfunction

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= 8'd7;
            row_total_reg  <= 8'd3;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH: row_length_reg <= cfg_data;
                REG_ROW_TOTAL:  row_total_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sizes in use: zero acts as one, and the row length is capped.
    always_comb
    begin
        len_eff = (row_length_reg == '0) ? CNT_ONE : row_length_reg;
        if (len_eff > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        rows_eff   = (row_total_reg == '0) ? CNT_ONE : row_total_reg;
        elem_total = {{(TALLY_W-COUNT_W){1'b0}}, len_eff}
                   * {{(TALLY_W-COUNT_W){1'b0}}, rows_eff};
    end

    // Run tracking for one element: value change, row close, array close.
    always_comb
    begin
        elem            = value[KEEP_W-1:0];
        held_value_next = held_value_reg;
        run_length_next = run_length_reg;
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        run_tally_next  = run_tally_reg;
        emit_change     = 1'b0;
        emit_row        = 1'b0;
        emit_verdict    = 1'b0;

        if (column_pos_reg == '0 || run_length_reg == '0)
        begin
            held_value_next = elem;
            run_length_next = CNT_ONE;
        end
        else if (elem == held_value_reg)
        begin
            if (run_length_reg != CNT_TOP)
            begin
                run_length_next = run_length_reg + CNT_ONE;
            end
        end
        else
        begin
            emit_change = 1'b1;
            if (run_tally_reg != TALLY_TOP)
            begin
                run_tally_next = run_tally_reg + TALLY_W'(1);
            end
            held_value_next = elem;
            run_length_next = CNT_ONE;
        end

        if (column_pos_reg != CNT_TOP)
        begin
            column_pos_next = column_pos_reg + CNT_ONE;
        end

        row_value     = held_value_next;
        row_count     = run_length_next;
        verdict_tally = '0;

        if (column_pos_next >= len_eff)
        begin
            emit_row = 1'b1;
            if (run_tally_next != TALLY_TOP)
            begin
                run_tally_next = run_tally_next + TALLY_W'(1);
            end
            column_pos_next = '0;
            run_length_next = '0;
            if (row_pos_reg != CNT_TOP)
            begin
                row_pos_next = row_pos_reg + CNT_ONE;
            end
            if (row_pos_next >= rows_eff)
            begin
                emit_verdict   = 1'b1;
                verdict_tally  = run_tally_next;
                row_pos_next   = '0;
                run_tally_next = '0;
            end
        end
    end

    // Pack the results of this element into consecutive slots.
    always_comb
    begin
        change_res = make_run(held_value_reg, run_length_reg, 1'b0);
        row_res    = make_run(row_value, row_count, 1'b1);

        verdict_res              = '0;
        verdict_res.kind         = KIND_VERDICT;
        verdict_res.total_runs   = verdict_tally;
        verdict_res.compressible = (verdict_tally < elem_total);

        n_results = {1'b0, emit_change} + {1'b0, emit_row} + {1'b0, emit_verdict};

        push.count   = in_fire ? n_results : 2'd0;
        push.slot[0] = emit_change ? change_res : row_res;
        push.slot[1] = emit_change ? row_res : verdict_res;
        push.slot[2] = verdict_res;
        for (int i = 0; i < RESULTS_MAX; i++)
        begin
            push.slot[i].last = (2'(i) == n_results - 2'd1);
        end
    end

    // State advances only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            run_length_reg <= '0;
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
            run_tally_reg  <= '0;
        end
        else if (in_fire)
        begin
            held_value_reg <= held_value_next;
            run_length_reg <= run_length_next;
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
            run_tally_reg  <= run_tally_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rlre_queue.sv]
// Result queue: takes up to three results a cycle, hands out one.
`default_nettype none

module rlre_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rlre_pkg::push_t  push,
    output logic                  space_ok,
    output logic                  head_valid,
    input  wire logic             head_taken,
    output rlre_pkg::result_t     head
);
    import rlre_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - RESULTS_MAX);

    result_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic              pop;

    // Room for a whole element's worth of results keeps the input open.
    assign space_ok   = (fill_reg <= ROOM_LIMIT);
    assign head_valid = (fill_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_taken;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Entry storage, written at consecutive slots from the write pointer.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RESULTS_MAX; i++)
        begin
            if (2'(i) < push.count)
            begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push.slot[i];
            end
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rlre_checker.sv]
// Port-level checks for the row run-length encoder, bound to the top level.
`default_nettype none

module rlre_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic [rlre_pkg::VALUE_W-1:0]     value,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic                             kind,
    input wire logic [rlre_pkg::VALUE_W-1:0]     run_value,
    input wire logic [rlre_pkg::COUNT_W-1:0]     run_count,
    input wire logic                             row_end,
    input wire logic [rlre_pkg::TALLY_W-1:0]     total_runs,
    input wire logic                             compressible,
    input wire logic                             last
);
    import rlre_pkg::*;

    // A waiting element keeps its valid and its value until its transfer.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(value))
        else $error("input element changed while waiting");

    // A stalled result keeps its contents until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(run_value) && $stable(run_count) && $stable(row_end)
            && $stable(total_runs) && $stable(compressible) && $stable(last))
        else $error("output result changed while stalled");

    // A verdict always ends the results of its element and carries no run.
    a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_VERDICT |->
            last && run_count == '0 && run_value == '0 && !row_end)
        else $error("malformed verdict result");

    // A run item has a nonzero length and no verdict fields.
    a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RUN |->
            run_count != '0 && total_runs == '0 && !compressible)
        else $error("malformed run result");

    // The input only closes when the queue holds results to hand out.
    a_ready_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input closed with nothing to deliver");

endmodule

bind row_run_length_encoder_top rlre_checker u_checker (.*);

`default_nettype wire
